// ===== rtl/core/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared control types, the round constant table and the initial hash words.
// ----------------------------------------------------------------------------
package shs_pkg;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       store_word;  // write a full message word into the block
      logic       load_pad;    // build the first closing block
      logic       load_tail;   // build the second closing block
      logic       init_vars;   // copy running hash into the working variables
      logic       round_en;    // run one compression round
      logic [5:0] round_idx;   // round number for the constant table
      logic       fold;        // add working variables into the running hash
      logic       clear_msg;   // back to the initial hash for the next message
      logic [2:0] out_idx;     // digest word on the result port
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic fill_last;   // next stored word completes the block
      logic two_blocks;  // padding needs a second closing block
   } status_type;

   localparam logic [31:0] PAD_WORD = 32'h8000_0000;

   // initial hash value, word 0 first
   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      logic [31:0] v;
      case (idx)
         3'd0: v = 32'h6A09E667;
         3'd1: v = 32'hBB67AE85;
         3'd2: v = 32'h3C6EF372;
         3'd3: v = 32'hA54FF53A;
         3'd4: v = 32'h510E527F;
         3'd5: v = 32'h9B05688C;
         3'd6: v = 32'h1F83D9AB;
         default: v = 32'h5BE0CD19;
      endcase
      return v;
   endfunction

   // round constants
   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] v;
      case (idx)
         6'd0:  v = 32'h428A2F98;  6'd1:  v = 32'h71374491;
         6'd2:  v = 32'hB5C0FBCF;  6'd3:  v = 32'hE9B5DBA5;
         6'd4:  v = 32'h3956C25B;  6'd5:  v = 32'h59F111F1;
         6'd6:  v = 32'h923F82A4;  6'd7:  v = 32'hAB1C5ED5;
         6'd8:  v = 32'hD807AA98;  6'd9:  v = 32'h12835B01;
         6'd10: v = 32'h243185BE;  6'd11: v = 32'h550C7DC3;
         6'd12: v = 32'h72BE5D74;  6'd13: v = 32'h80DEB1FE;
         6'd14: v = 32'h9BDC06A7;  6'd15: v = 32'hC19BF174;
         6'd16: v = 32'hE49B69C1;  6'd17: v = 32'hEFBE4786;
         6'd18: v = 32'h0FC19DC6;  6'd19: v = 32'h240CA1CC;
         6'd20: v = 32'h2DE92C6F;  6'd21: v = 32'h4A7484AA;
         6'd22: v = 32'h5CB0A9DC;  6'd23: v = 32'h76F988DA;
         6'd24: v = 32'h983E5152;  6'd25: v = 32'hA831C66D;
         6'd26: v = 32'hB00327C8;  6'd27: v = 32'hBF597FC7;
         6'd28: v = 32'hC6E00BF3;  6'd29: v = 32'hD5A79147;
         6'd30: v = 32'h06CA6351;  6'd31: v = 32'h14292967;
         6'd32: v = 32'h27B70A85;  6'd33: v = 32'h2E1B2138;
         6'd34: v = 32'h4D2C6DFC;  6'd35: v = 32'h53380D13;
         6'd36: v = 32'h650A7354;  6'd37: v = 32'h766A0ABB;
         6'd38: v = 32'h81C2C92E;  6'd39: v = 32'h92722C85;
         6'd40: v = 32'hA2BFE8A1;  6'd41: v = 32'hA81A664B;
         6'd42: v = 32'hC24B8B70;  6'd43: v = 32'hC76C51A3;
         6'd44: v = 32'hD192E819;  6'd45: v = 32'hD6990624;
         6'd46: v = 32'hF40E3585;  6'd47: v = 32'h106AA070;
         6'd48: v = 32'h19A4C116;  6'd49: v = 32'h1E376C08;
         6'd50: v = 32'h2748774C;  6'd51: v = 32'h34B0BCB5;
         6'd52: v = 32'h391C0CB3;  6'd53: v = 32'h4ED8AA4A;
         6'd54: v = 32'h5B9CCA4F;  6'd55: v = 32'h682E6FF3;
         6'd56: v = 32'h748F82EE;  6'd57: v = 32'h78A5636F;
         6'd58: v = 32'h84C87814;  6'd59: v = 32'h8CC70208;
         6'd60: v = 32'h90BEFFFA;  6'd61: v = 32'hA4506CEB;
         6'd62: v = 32'hBEF9A3F7;  default: v = 32'hC67178F2;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/shs_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher controller
// Sequences word intake, block compression, padding blocks and digest output.
// ----------------------------------------------------------------------------
module shs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_final_word,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  shs_pkg::status_type status,
   output shs_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_TAIL,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      BLK_DATA,
      BLK_PAD,
      BLK_TAIL
   } block_type;

   state_type  state_ff, state_in;
   block_type  kind_ff, kind_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] out_idx_ff, out_idx_in;
   logic       req_take;
   logic       rsp_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign rsp_take  = rsp_valid && !rsp_stall;

   // next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      round_in   = round_ff;
      out_idx_in = out_idx_ff;
      cmd        = '0;
      cmd.round_idx = round_ff;
      cmd.out_idx   = out_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               round_in = '0;
               if (req_final_word) begin
                  cmd.load_pad  = 1'b1;
                  cmd.init_vars = 1'b1;
                  kind_in       = BLK_PAD;
                  state_in      = ST_ROUND;
               end else begin
                  cmd.store_word = 1'b1;
                  if (status.fill_last) begin
                     cmd.init_vars = 1'b1;
                     kind_in       = BLK_DATA;
                     state_in      = ST_ROUND;
                  end
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold   = 1'b1;
            out_idx_in = '0;
            unique case (kind_ff)
               BLK_DATA: state_in = ST_IDLE;
               BLK_PAD:  state_in = status.two_blocks ? ST_TAIL : ST_OUT;
               default:  state_in = ST_OUT;
            endcase
         end
         ST_TAIL: begin
            cmd.load_tail = 1'b1;
            cmd.init_vars = 1'b1;
            round_in      = '0;
            kind_in       = BLK_TAIL;
            state_in      = ST_ROUND;
         end
         ST_OUT: begin
            if (rsp_take) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  cmd.clear_msg = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         kind_ff    <= BLK_DATA;
         round_ff   <= '0;
         out_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         kind_ff    <= kind_in;
         round_ff   <= round_in;
         out_idx_ff <= out_idx_in;
      end
   end

endmodule

// ===== rtl/core/shs_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher datapath
// Message window, working variables, running hash, length and padding logic.
// ----------------------------------------------------------------------------
module shs_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         req_data_word,
   input  logic [2:0]          req_valid_bytes,
   input  shs_pkg::cmd_type    cmd,
   output shs_pkg::status_type status,
   output logic [31:0]         rsp_digest_word
);

   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] vars_ff [8];
   logic [31:0] vars_in [8];
   logic [31:0] hash_ff [8];
   logic [31:0] hash_in [8];
   logic [3:0]  fill_ff, fill_in;
   logic [63:0] length_ff, length_in;
   logic        two_ff, two_in;
   logic        lead_ff, lead_in;

   logic [2:0]  byte_cnt;
   logic [6:0]  end_pos;
   logic [31:0] pad_word;
   logic [63:0] length_fin;
   logic [31:0] sched_new;
   logic [31:0] t1, t2;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // clamp byte count, locate the end of the message in the block
   always_comb begin
      byte_cnt   = (req_valid_bytes > 3'd4) ? 3'd4 : req_valid_bytes;
      end_pos    = {1'b0, fill_ff, 2'b00} + {4'b0, byte_cnt};
      length_fin = length_ff + {58'b0, byte_cnt, 3'b000};
      case (byte_cnt)
         3'd0:    pad_word = shs_pkg::PAD_WORD;
         3'd1:    pad_word = {req_data_word[31:24], 8'h80, 16'h0};
         3'd2:    pad_word = {req_data_word[31:16], 8'h80, 8'h0};
         3'd3:    pad_word = {req_data_word[31:8], 8'h80};
         default: pad_word = req_data_word;
      endcase
   end

   // message schedule and round function
   always_comb begin
      sched_new = (rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10))
                + w_ff[9]
                + (rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3))
                + w_ff[0];
      t1 = vars_ff[7]
         + (rotr(vars_ff[4], 6) ^ rotr(vars_ff[4], 11) ^ rotr(vars_ff[4], 25))
         + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
         + shs_pkg::round_const(cmd.round_idx)
         + w_ff[0];
      t2 = (rotr(vars_ff[0], 2) ^ rotr(vars_ff[0], 13) ^ rotr(vars_ff[0], 22))
         + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
            ^ (vars_ff[1] & vars_ff[2]));
   end

   // message window: store, build padding blocks, shift during rounds
   always_comb begin
      for (int j = 0; j < 16; j++) begin
         w_in[j] = w_ff[j];
      end
      two_in  = two_ff;
      lead_in = lead_ff;
      if (cmd.store_word) begin
         w_in[fill_ff] = req_data_word;
      end else if (cmd.load_pad) begin
         two_in  = (end_pos > 7'd55);
         lead_in = (end_pos == 7'd64);
         for (int j = 0; j < 16; j++) begin
            if (4'(j) == fill_ff) begin
               w_in[j] = pad_word;
            end else if (4'(j) > fill_ff) begin
               w_in[j] = ((4'(j) == fill_ff + 4'd1) && (byte_cnt == 3'd4)) ?
                         shs_pkg::PAD_WORD : 32'h0;
            end
         end
         if (end_pos <= 7'd55) begin
            w_in[14] = length_fin[63:32];
            w_in[15] = length_fin[31:0];
         end
      end else if (cmd.load_tail) begin
         for (int j = 1; j < 14; j++) begin
            w_in[j] = 32'h0;
         end
         w_in[0]  = lead_ff ? shs_pkg::PAD_WORD : 32'h0;
         w_in[14] = length_ff[63:32];
         w_in[15] = length_ff[31:0];
      end else if (cmd.round_en) begin
         for (int j = 0; j < 15; j++) begin
            w_in[j] = w_ff[j + 1];
         end
         w_in[15] = sched_new;
      end
   end

   // working variables, running hash, fill and length
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         vars_in[j] = vars_ff[j];
         hash_in[j] = hash_ff[j];
      end
      fill_in   = fill_ff;
      length_in = length_ff;
      if (cmd.init_vars) begin
         for (int j = 0; j < 8; j++) begin
            vars_in[j] = hash_ff[j];
         end
      end else if (cmd.round_en) begin
         vars_in[0] = t1 + t2;
         vars_in[1] = vars_ff[0];
         vars_in[2] = vars_ff[1];
         vars_in[3] = vars_ff[2];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[5] = vars_ff[4];
         vars_in[6] = vars_ff[5];
         vars_in[7] = vars_ff[6];
      end
      if (cmd.fold) begin
         for (int j = 0; j < 8; j++) begin
            hash_in[j] = hash_ff[j] + vars_ff[j];
         end
      end
      if (cmd.store_word) begin
         fill_in   = fill_ff + 4'd1;
         length_in = length_ff + 64'd32;
      end
      if (cmd.load_pad) begin
         length_in = length_fin;
      end
      if (cmd.clear_msg) begin
         for (int j = 0; j < 8; j++) begin
            hash_in[j] = shs_pkg::init_hash(3'(j));
         end
         fill_in   = '0;
         length_in = '0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int j = 0; j < 16; j++) begin
         w_ff[j] <= w_in[j];
      end
      for (int j = 0; j < 8; j++) begin
         vars_ff[j] <= vars_in[j];
      end
      two_ff  <= two_in;
      lead_ff <= lead_in;
   end

   // message state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 8; j++) begin
            hash_ff[j] <= shs_pkg::init_hash(3'(j));
         end
         fill_ff   <= '0;
         length_ff <= '0;
      end else begin
         for (int j = 0; j < 8; j++) begin
            hash_ff[j] <= hash_in[j];
         end
         fill_ff   <= fill_in;
         length_ff <= length_in;
      end
   end

   assign status.fill_last  = (fill_ff == 4'd15);
   assign status.two_blocks = two_ff;
   assign rsp_digest_word   = hash_ff[cmd.out_idx];

endmodule

// ===== rtl/core/sha256_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a word stream with SHA-256 and returns the digest as eight words.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes 32-bit big-endian message words with a byte count
//   and a final flag. Words before the final one carry four bytes. The final
//   word carries zero to four bytes and closes the message.
//   A plain word is stored straight into the block. For the word that
//   completes a 64-byte block, the 64-round compression runs one round per
//   cycle in the shared round unit, then the fold adds into the running hash.
//   A final word runs one or two closing blocks through compression, then
//   the rsp channel returns eight transactions, digest word 0 first, with
//   digest_last on word 7. The next message starts from the initial hash.
//   req_stall is high whenever the block is compressing or sending the
//   digest; only one message item is in work at a time.
//   When the receiver stalls rsp, the current digest word holds and the
//   block waits. Synchronous reset loads the initial hash, clears the block
//   word fill count and length, and drops any message in work.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_final_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_digest_last
);

   shs_pkg::cmd_type    cmd;
   shs_pkg::status_type status;

   shs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_final_word (req_final_word),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .cmd            (cmd)
   );

   shs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .cmd             (cmd),
      .status          (status),
      .rsp_digest_word (rsp_digest_word)
   );

   // tag the digest word position
   assign rsp_word_index  = cmd.out_idx;
   assign rsp_digest_last = (cmd.out_idx == 3'd7);

endmodule

// ===== sim/sha256_stream_hasher_top_test.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Sends message words with random sender gaps and receiver stalls. A local
// SHA-256 predictor expects eight digest words for each message. Every
// digest transaction is checked against the oldest expected word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sha256_stream_hasher_top_test;

   // one expected digest transaction
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  idx;
      logic        last;
   } digest_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_valid_bytes = '0;
   logic        req_final_word = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_digest_last;

   sha256_stream_hasher_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_final_word  (req_final_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_digest_last (rsp_digest_last)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // SHA-256 predictor
   // ---------------------------------------------------------------------
   bit [31:0] round_k [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
   };

   bit [31:0] start_hash [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   bit [31:0]       run_hash [8];
   bit [31:0]       msg_block [16];
   int              block_fill;
   bit [63:0]       msg_bits;
   digest_beat_type digest_queue [$];

   function automatic bit [31:0] ror(input bit [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // start a new message from the initial hash
   function automatic void sha_restart();
      for (int i = 0; i < 8; i++) run_hash[i] = start_hash[i];
      block_fill = 0;
      msg_bits = '0;
   endfunction

   // fold the current 64-byte block into the running hash
   function automatic void sha_compress();
      bit [31:0] w [64];
      bit [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;
      for (int t = 0; t < 16; t++) w[t] = msg_block[t];
      for (int t = 16; t < 64; t++) begin
         s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      a = run_hash[0]; b = run_hash[1]; c = run_hash[2]; d = run_hash[3];
      e = run_hash[4]; f = run_hash[5]; g = run_hash[6]; h = run_hash[7];
      for (int t = 0; t < 64; t++) begin
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
              + round_k[t] + w[t];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      run_hash[0] += a; run_hash[1] += b; run_hash[2] += c; run_hash[3] += d;
      run_hash[4] += e; run_hash[5] += f; run_hash[6] += g; run_hash[7] += h;
   endfunction

   function automatic void put_byte(input int pos, input bit [7:0] v);
      msg_block[pos / 4][31 - 8 * (pos % 4) -: 8] = v;
   endfunction

   // absorb one message word; a final word pads, closes and queues the digest
   function automatic void sha_absorb(input bit [31:0] data, input bit [2:0] nbytes,
                                      input bit fin);
      int              pos;
      int              cnt;
      digest_beat_type beat;
      pos = block_fill;
      if (!fin) begin
         // non-final words always carry four bytes
         msg_block[pos / 4] = data;
         msg_bits += 64'd32;
         pos += 4;
         if (pos == 64) begin
            sha_compress();
            pos = 0;
         end
         block_fill = pos;
         return;
      end
      // clamp oversized counts to a full word
      cnt = (nbytes > 3'd4) ? 4 : int'(nbytes);
      msg_bits += 64'(8 * cnt);
      for (int i = 0; i < cnt; i++) begin
         put_byte(pos, data[31 - 8 * i -: 8]);
         pos++;
         if (pos == 64) begin
            sha_compress();
            pos = 0;
         end
      end
      put_byte(pos, 8'h80);
      pos++;
      // no room for the length: close this block and open another
      if (pos > 56) begin
         while (pos < 64) begin
            put_byte(pos, 8'h00);
            pos++;
         end
         sha_compress();
         pos = 0;
      end
      while (pos < 56) begin
         put_byte(pos, 8'h00);
         pos++;
      end
      msg_block[14] = msg_bits[63:32];
      msg_block[15] = msg_bits[31:0];
      sha_compress();
      for (int i = 0; i < 8; i++) begin
         beat.word = run_hash[i];
         beat.idx  = 3'(i);
         beat.last = (i == 7);
         digest_queue.push_back(beat);
      end
      sha_restart();
   endfunction

   // ---------------------------------------------------------------------
   // Digest checker
   // ---------------------------------------------------------------------
   int              fail_count = 0;
   digest_beat_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_queue.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected digest word %h idx %0d last %0b",
                        rsp_digest_word, rsp_word_index, rsp_digest_last);
         end else begin
            want = digest_queue.pop_front();
            if (rsp_digest_word !== want.word || rsp_word_index !== want.idx ||
                rsp_digest_last !== want.last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("digest mismatch: want %h idx %0d last %0b, got %h idx %0d last %0b",
                           want.word, want.idx, want.last,
                           rsp_digest_word, rsp_word_index, rsp_digest_last);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver stall: mostly short, a few long, with stall-free stretches
   // ---------------------------------------------------------------------
   int stall_run = 0;
   int stall_pick;
   int rsp_phase = 0;
   bit rsp_quiet = 1'b0;

   always @(negedge clock) begin
      rsp_phase++;
      if (rsp_phase % 300 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run--;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (rsp_quiet || stall_pick < 65) begin
            rsp_stall <= 1'b0;
         end else if (stall_pick < 95) begin
            rsp_stall <= 1'b1;
            stall_run = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_run = $urandom_range(10, 40);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------
   int gap_left = 0;
   bit send_quiet = 1'b0;

   function automatic int pick_gap();
      int r;
      if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
      if (send_quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // drive one word, hold until accepted, then predict it
   task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                            input logic fin);
      if (gap_left > 0) repeat (gap_left) @(negedge clock);
      req_valid       <= 1'b1;
      req_data_word   <= data;
      req_valid_bytes <= nbytes;
      req_final_word  <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sha_absorb(data, nbytes, fin);
      @(negedge clock);
      gap_left = pick_gap();
      if (gap_left > 0) req_valid <= 1'b0;
   endtask

   // drop valid and hold until every expected digest word has arrived
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      gap_left = 0;
      do @(negedge clock); while (digest_queue.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // short final words: empty, partial with junk in unused bytes, full
   task automatic test_short_finals();
      send_word($urandom, 3'd0, 1'b1);
      send_word(32'h616263A5, 3'd3, 1'b1);
      send_word(32'hFFFFFFFF, 3'd4, 1'b1);
      send_word(32'h00000000, 3'd2, 1'b1);
      send_word(32'h5AFFFFFF, 3'd1, 1'b1);
   endtask

   // byte counts above four on a final word count as four
   task automatic test_oversized_count();
      send_word($urandom, 3'd5, 1'b1);
      send_word($urandom, 3'd6, 1'b1);
      send_word(32'hFFFFFFFF, 3'd7, 1'b1);
   endtask

   // short counts on non-final words are ignored
   task automatic test_short_nonfinal();
      send_word(32'hDEADBEEF, 3'd0, 1'b0);
      send_word(32'h01234567, 3'd3, 1'b0);
      send_word($urandom, 3'd1, 1'b1);
   endtask

   // 55-byte message: marker and length just fit one closing block
   task automatic test_padding_fits();
      for (int i = 0; i < 13; i++) send_word($urandom, 3'd4, 1'b0);
      send_word($urandom, 3'd3, 1'b1);
   endtask

   // random messages, biased toward the block and padding boundaries
   task automatic test_random_messages();
      int words;
      int kind;
      int sent;
      int msgs;
      sent = 0;
      msgs = 0;
      while (sent < 150 || msgs < 8) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) words = $urandom_range(0, 8);
         else if (kind < 8) words = 16 * $urandom_range(0, 1) + $urandom_range(13, 15);
         else words = $urandom_range(16, 40);
         for (int i = 0; i < words; i++)
            send_word($urandom,
                      ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                      1'b0);
         send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
         sent += words + 1;
         msgs++;
         if ($urandom_range(0, 5) == 0) hold_until_drained();
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      sha_restart();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_short_finals();
      test_oversized_count();
      test_short_nonfinal();
      test_padding_fits();
      hold_until_drained();
      test_random_messages();

      // wait out the tail, then report
      hold_until_drained();
      repeat (200) @(negedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/shs_pkg.sv
rtl/core/shs_ctrl.sv
rtl/core/shs_datapath.sv
rtl/core/sha256_stream_hasher_top.sv
sim/sha256_stream_hasher_top_test.sv
